// ===== hw/rtl/ps2md_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse decoder package
// Result kinds, request modes, register indexes and byte 0 field masks of a mouse packet.
// ----------------------------------------------------------------------------
package ps2md_pkg;

   // result kind of one transfer on the response channel
   typedef enum logic [2:0] {
      KIND_STORED   = 3'd0,
      KIND_PACKET   = 3'd1,
      KIND_SYNC     = 3'd2,
      KIND_OVERFLOW = 3'd3,
      KIND_REPORT   = 3'd4,
      KIND_IGNORED  = 3'd5
   } kind_type;

   // request modes
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // control register indexes
   localparam logic CSR_ENABLED    = 1'b0;
   localparam logic CSR_WHEEL_MODE = 1'b1;

   // byte 0 fields
   localparam logic [7:0] SYNC_MASK   = 8'h08;
   localparam logic [7:0] OVF_MASK    = 8'hC0;
   localparam logic [7:0] X_SIGN_MASK = 8'h10;
   localparam logic [7:0] Y_SIGN_MASK = 8'h20;
   localparam logic [7:0] BTN_MASK    = 8'h07;

   // packet layout
   localparam int unsigned HELD_BYTES = 3;

endpackage : ps2md_pkg
`default_nettype wire

// ===== hw/rtl/ps2_mouse_packet_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Assembles mouse bytes into 3- or 4-byte packets, decodes motion, wheel and
// buttons, and keeps saturating motion sums that a read request returns.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transfer per item; req_mode 0 delivers a mouse byte in
//            req_data_byte, req_mode 1 reads and clears the motion sums.
//   rsp_*  : exactly one result transfer per request, in request order.
//   csr_*  : register writes (index 0 enabled, index 1 wheel_mode); always
//            ready, write only while no request is in flight.
// Path: a request taken is held in the input register, then moves to the
//   result register once that register is empty or its result is being taken.
// Throughput: one request per cycle while the result channel is not stalled;
//   decode, sum update and result select sit between the input register and
//   the result register, and the state (byte position, sums, count) updates
//   as each item leaves the input register.
// Stall: when rsp_ready is low the result register holds; the input register
//   still takes one more request, then req_ready drops until the result moves.
// Reset: both registers empty, decoding disabled, three-byte mode, byte
//   position, sums, button history and packet count cleared.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top
   import ps2md_pkg::*;
#(
   parameter int ACC_WIDTH = 16
) (
   input  wire                clock,
   input  wire                reset,
   // configuration writes
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire                csr_index,
   input  wire                csr_data,
   // requests
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_mode,
   input  wire         [7:0]  req_data_byte,
   // results
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic        [2:0]  rsp_kind,
   output logic signed [8:0]  rsp_move_x,
   output logic signed [9:0]  rsp_move_y,
   output logic signed [3:0]  rsp_wheel_step,
   output logic        [2:0]  rsp_button_bits,
   output logic        [2:0]  rsp_changed_bits,
   output logic signed [15:0] rsp_sum_x,
   output logic signed [15:0] rsp_sum_y,
   output logic signed [15:0] rsp_sum_wheel,
   output logic        [15:0] rsp_event_count
);

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   // configuration
   logic enabled_ff, enabled_in;
   logic wheel_mode_ff, wheel_mode_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_mode_ff, in_mode_in;
   logic [7:0] in_data_ff, in_data_in;

   // decoder state
   logic [1:0]           byte_index_ff, byte_index_in;
   logic [7:0]           pkt_ff [HELD_BYTES];
   logic [7:0]           pkt_in [HELD_BYTES];
   logic [ACC_WIDTH-1:0] acc_x_ff, acc_x_in;
   logic [ACC_WIDTH-1:0] acc_y_ff, acc_y_in;
   logic [ACC_WIDTH-1:0] acc_w_ff, acc_w_in;
   logic [2:0]           last_btn_ff, last_btn_in;
   logic [15:0]          seq_ff, seq_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    kind_ff, kind_in;
   logic [8:0]  move_x_ff, move_x_in;
   logic [9:0]  move_y_ff, move_y_in;
   logic [3:0]  wheel_ff, wheel_in;
   logic [2:0]  btn_ff, btn_in;
   logic [2:0]  chg_ff, chg_in;
   logic [15:0] sum_x_ff, sum_x_in;
   logic [15:0] sum_y_ff, sum_y_in;
   logic [15:0] sum_w_ff, sum_w_in;
   logic [15:0] count_ff, count_in;

   // datapath
   logic             advance;
   logic             last_byte;
   logic [7:0]       b0, b1, b2;
   logic [8:0]       dx;
   logic [8:0]       dy_raw;
   logic [9:0]       dy;
   logic [3:0]       wheel;
   logic [ACC_WIDTH:0] sum_x_ext, sum_y_ext, sum_w_ext;
   logic [15:0]      rep_x, rep_y, rep_w;

   // clamp a sum one bit wider than the accumulator to the accumulator range
   function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [ACC_WIDTH:0] s);
      logic [ACC_WIDTH-1:0] r;
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         r = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         r = s[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   // handshakes
   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // configuration writes
   always_comb begin
      enabled_in    = enabled_ff;
      wheel_mode_in = wheel_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLED:    enabled_in    = csr_data;
            CSR_WHEEL_MODE: wheel_mode_in = csr_data;
            default:        enabled_in    = enabled_ff;
         endcase
      end
   end

   // load the input register on a request transfer, hold while stalled
   always_comb begin
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
      in_mode_in  = in_mode_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_mode_in = req_mode;
         in_data_in = req_data_byte;
      end
   end

   // packet fields
   assign last_byte = wheel_mode_ff ? (byte_index_ff == 2'd3) : (byte_index_ff >= 2'd2);
   assign b0     = pkt_ff[0];
   assign b1     = pkt_ff[1];
   assign b2     = (byte_index_ff == 2'd2) ? in_data_ff : pkt_ff[2];
   assign dx     = {|(b0 & X_SIGN_MASK), b1};
   assign dy_raw = {|(b0 & Y_SIGN_MASK), b2};
   assign dy     = 10'(-$signed({dy_raw[8], dy_raw}));
   assign wheel  = wheel_mode_ff ? in_data_ff[3:0] : 4'd0;

   // motion sums with one guard bit
   assign sum_x_ext = {acc_x_ff[ACC_WIDTH-1], acc_x_ff}
                    + {{(ACC_WIDTH+1-9){dx[8]}}, dx};
   assign sum_y_ext = {acc_y_ff[ACC_WIDTH-1], acc_y_ff}
                    + {{(ACC_WIDTH+1-10){dy[9]}}, dy};
   assign sum_w_ext = {acc_w_ff[ACC_WIDTH-1], acc_w_ff}
                    + {{(ACC_WIDTH+1-4){wheel[3]}}, wheel};

   // reported sums in the 16-bit range
   generate
      if (ACC_WIDTH == 16) begin : g_rep_same
         assign rep_x = acc_x_ff;
         assign rep_y = acc_y_ff;
         assign rep_w = acc_w_ff;
      end else if (ACC_WIDTH < 16) begin : g_rep_extend
         assign rep_x = {{(16-ACC_WIDTH){acc_x_ff[ACC_WIDTH-1]}}, acc_x_ff};
         assign rep_y = {{(16-ACC_WIDTH){acc_y_ff[ACC_WIDTH-1]}}, acc_y_ff};
         assign rep_w = {{(16-ACC_WIDTH){acc_w_ff[ACC_WIDTH-1]}}, acc_w_ff};
      end else begin : g_rep_clamp
         logic [ACC_WIDTH-16:0] up_x, up_y, up_w;
         assign up_x  = acc_x_ff[ACC_WIDTH-1:15];
         assign up_y  = acc_y_ff[ACC_WIDTH-1:15];
         assign up_w  = acc_w_ff[ACC_WIDTH-1:15];
         assign rep_x = ((&up_x) || !(|up_x)) ? acc_x_ff[15:0]
                      : (up_x[ACC_WIDTH-16] ? 16'h8000 : 16'h7FFF);
         assign rep_y = ((&up_y) || !(|up_y)) ? acc_y_ff[15:0]
                      : (up_y[ACC_WIDTH-16] ? 16'h8000 : 16'h7FFF);
         assign rep_w = ((&up_w) || !(|up_w)) ? acc_w_ff[15:0]
                      : (up_w[ACC_WIDTH-16] ? 16'h8000 : 16'h7FFF);
      end
   endgenerate

   // decode the held item into a result and the next state
   always_comb begin
      byte_index_in = byte_index_ff;
      for (int i = 0; i < HELD_BYTES; i++) begin
         pkt_in[i] = pkt_ff[i];
      end
      acc_x_in    = acc_x_ff;
      acc_y_in    = acc_y_ff;
      acc_w_in    = acc_w_ff;
      last_btn_in = last_btn_ff;
      seq_in      = seq_ff;

      kind_in   = KIND_IGNORED;
      move_x_in = '0;
      move_y_in = '0;
      wheel_in  = '0;
      btn_in    = '0;
      chg_in    = '0;
      sum_x_in  = '0;
      sum_y_in  = '0;
      sum_w_in  = '0;
      count_in  = '0;

      if (!enabled_ff) begin
         kind_in = KIND_IGNORED;
      end else if (in_mode_ff == REQ_READ) begin
         kind_in  = KIND_REPORT;
         btn_in   = last_btn_ff;
         sum_x_in = rep_x;
         sum_y_in = rep_y;
         sum_w_in = rep_w;
         count_in = seq_ff;
         acc_x_in = '0;
         acc_y_in = '0;
         acc_w_in = '0;
      end else if (byte_index_ff == 2'd0 && (in_data_ff & SYNC_MASK) == 8'h00) begin
         kind_in = KIND_SYNC;
      end else if (!last_byte) begin
         kind_in                = KIND_STORED;
         pkt_in[byte_index_ff]  = in_data_ff;
         byte_index_in          = byte_index_ff + 2'd1;
      end else begin
         byte_index_in = 2'd0;
         if ((b0 & OVF_MASK) != 8'h00) begin
            kind_in = KIND_OVERFLOW;
         end else begin
            kind_in     = KIND_PACKET;
            move_x_in   = dx;
            move_y_in   = dy;
            wheel_in    = wheel;
            btn_in      = 3'(b0 & BTN_MASK);
            chg_in      = last_btn_ff ^ 3'(b0 & BTN_MASK);
            last_btn_in = 3'(b0 & BTN_MASK);
            acc_x_in    = sat_acc(sum_x_ext);
            acc_y_in    = sat_acc(sum_y_ext);
            acc_w_in    = sat_acc(sum_w_ext);
            seq_in      = seq_ff + 16'd1;
            count_in    = seq_ff + 16'd1;
         end
      end
   end

   // result register valid
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         wheel_mode_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_index_ff <= '0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         acc_w_ff      <= '0;
         last_btn_ff   <= '0;
         seq_ff        <= '0;
      end else begin
         enabled_ff    <= enabled_in;
         wheel_mode_ff <= wheel_mode_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            byte_index_ff <= byte_index_in;
            acc_x_ff      <= acc_x_in;
            acc_y_ff      <= acc_y_in;
            acc_w_ff      <= acc_w_in;
            last_btn_ff   <= last_btn_in;
            seq_ff        <= seq_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_mode_ff <= in_mode_in;
      in_data_ff <= in_data_in;
      if (advance) begin
         for (int i = 0; i < HELD_BYTES; i++) begin
            pkt_ff[i] <= pkt_in[i];
         end
         kind_ff   <= kind_in;
         move_x_ff <= move_x_in;
         move_y_ff <= move_y_in;
         wheel_ff  <= wheel_in;
         btn_ff    <= btn_in;
         chg_ff    <= chg_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_w_ff  <= sum_w_in;
         count_ff  <= count_in;
      end
   end

   // drive the result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_move_x       = move_x_ff;
   assign rsp_move_y       = move_y_ff;
   assign rsp_wheel_step   = wheel_ff;
   assign rsp_button_bits  = btn_ff;
   assign rsp_changed_bits = chg_ff;
   assign rsp_sum_x        = sum_x_ff;
   assign rsp_sum_y        = sum_y_ff;
   assign rsp_sum_wheel    = sum_w_ff;
   assign rsp_event_count  = count_ff;

`ifndef SYNTHESIS
   // a read leaves the sums cleared
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && enabled_ff && in_mode_ff == REQ_READ)
      |=> (acc_x_ff == '0 && acc_y_ff == '0 && acc_w_ff == '0))
      else $error("motion sums not cleared after read");

   // a packet bumps the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_in == KIND_PACKET)
      |=> (seq_ff == $past(seq_ff) + 16'd1))
      else $error("packet count did not advance by one");

   // the byte position moves only when an item leaves the input register
   a_index_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(byte_index_ff))
      else $error("byte position changed without an item");

   // back pressure only with both registers full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with room in the pipeline");

   // motion fields are zero outside packet results
   a_motion_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_PACKET)
      |-> (rsp_move_x == '0 && rsp_move_y == '0 && rsp_changed_bits == '0))
      else $error("motion reported outside a packet result");
`endif

endmodule : ps2_mouse_packet_decoder_top
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder testbench
// Feeds mouse bytes and read requests through the request channel with random
// gaps and result-side stalls, predicts every result with an independent
// decoder kept in a small scoreboard class, and compares the results field by
// field. Covers disabled operation, sync and overflow drops, three- and
// four-byte packets, packet size changes mid-packet and sum saturation.
// ----------------------------------------------------------------------------
module tb
   import ps2md_pkg::*;
();

   localparam int ACC_BITS     = 16;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   // shape of the motion carried by generated packets
   typedef enum int {
      MOTION_ANY,
      MOTION_RIGHT_UP,
      MOTION_LEFT_DOWN
   } motion_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [8:0]  move_x;
      logic signed [9:0]  move_y;
      logic signed [3:0]  wheel_step;
      logic        [2:0]  button_bits;
      logic        [2:0]  changed_bits;
      logic signed [15:0] sum_x;
      logic signed [15:0] sum_y;
      logic signed [15:0] sum_wheel;
      logic        [15:0] event_count;
   } mouse_result_type;

   // Decoder state, predicted results in request order, and result checking.
   class mouse_tracker;
      bit                 enabled;
      bit                 wheel_mode;
      logic [1:0]         byte_pos;
      logic [7:0]         held [3];
      longint             acc_x;
      longint             acc_y;
      longint             acc_wheel;
      logic [2:0]         last_buttons;
      logic [15:0]        event_total;
      mouse_result_type   decoded_q [$];
      int                 mismatches;
      int                 checked;
      int                 kind_seen [6];

      function new();
         enabled      = 1'b0;
         wheel_mode   = 1'b0;
         byte_pos     = '0;
         held         = '{default: '0};
         acc_x        = 0;
         acc_y        = 0;
         acc_wheel    = 0;
         last_buttons = '0;
         event_total  = '0;
         mismatches   = 0;
         checked      = 0;
         kind_seen    = '{default: 0};
      endfunction

      function void write_register(logic idx, logic val);
         if (idx == CSR_ENABLED) begin
            enabled = val;
         end else begin
            wheel_mode = val;
         end
      endfunction

      // clamp to the signed range of the given width
      function longint clamp(longint v, int bits);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction

      // work out the result of one accepted request and advance the state
      function void take_request(logic mode, logic [7:0] data);
         mouse_result_type r;
         logic [7:0]    b0;
         logic [7:0]    b1;
         logic [7:0]    b2;
         int            dx;
         int            dy;
         int            wheel;
         int            size;
         logic [2:0]    buttons;
         r    = '0;
         size = wheel_mode ? 4 : 3;
         if (!enabled) begin
            r.kind = KIND_IGNORED;
         end else if (mode == REQ_READ) begin
            // report the sums and clear them
            r.kind        = KIND_REPORT;
            r.button_bits = last_buttons;
            r.sum_x       = 16'(clamp(acc_x, 16));
            r.sum_y       = 16'(clamp(acc_y, 16));
            r.sum_wheel   = 16'(clamp(acc_wheel, 16));
            r.event_count = event_total;
            acc_x         = 0;
            acc_y         = 0;
            acc_wheel     = 0;
         end else if (byte_pos == 2'd0 && (data & SYNC_MASK) == 8'h00) begin
            r.kind = KIND_SYNC;
         end else if (int'(byte_pos) + 1 < size) begin
            held[byte_pos] = data;
            byte_pos       = byte_pos + 2'd1;
            r.kind         = KIND_STORED;
         end else begin
            // packet complete; the closing byte is used directly
            b0       = held[0];
            b1       = held[1];
            b2       = (byte_pos == 2'd2) ? data : held[2];
            byte_pos = '0;
            if ((b0 & OVF_MASK) != 8'h00) begin
               r.kind = KIND_OVERFLOW;
            end else begin
               dx    = int'(b1) - (((b0 & X_SIGN_MASK) != 8'h00) ? 256 : 0);
               dy    = int'(b2) - (((b0 & Y_SIGN_MASK) != 8'h00) ? 256 : 0);
               wheel = 0;
               if (wheel_mode) begin
                  wheel = data[3] ? int'(data[3:0]) - 16 : int'(data[3:0]);
               end
               dy           = -dy;
               buttons      = 3'(b0 & BTN_MASK);
               r.kind       = KIND_PACKET;
               r.move_x     = 9'(dx);
               r.move_y     = 10'(dy);
               r.wheel_step = 4'(wheel);
               r.button_bits  = buttons;
               r.changed_bits = last_buttons ^ buttons;
               last_buttons = buttons;
               acc_x        = clamp(acc_x + dx, ACC_BITS);
               acc_y        = clamp(acc_y + dy, ACC_BITS);
               acc_wheel    = clamp(acc_wheel + wheel, ACC_BITS);
               event_total  = event_total + 16'd1;
               r.event_count = event_total;
            end
         end
         kind_seen[int'(r.kind)]++;
         decoded_q.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [16:0] want,
                                  logic signed [16:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
         end
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_result(mouse_result_type got);
         mouse_result_type want;
         if (decoded_q.size() == 0) begin
            $error("result with no request waiting: kind %0d", got.kind);
            mismatches++;
            return;
         end
         want = decoded_q.pop_front();
         checked++;
         compare_field("kind", want.kind, got.kind);
         compare_field("move_x", want.move_x, got.move_x);
         compare_field("move_y", want.move_y, got.move_y);
         compare_field("wheel_step", want.wheel_step, got.wheel_step);
         compare_field("button_bits", want.button_bits, got.button_bits);
         compare_field("changed_bits", want.changed_bits, got.changed_bits);
         compare_field("sum_x", want.sum_x, got.sum_x);
         compare_field("sum_y", want.sum_y, got.sum_y);
         compare_field("sum_wheel", want.sum_wheel, got.sum_wheel);
         compare_field("event_count", want.event_count, got.event_count);
      endfunction
   endclass

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   logic              csr_index     = 1'b0;
   logic              csr_data      = 1'b0;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic              req_mode      = 1'b0;
   logic [7:0]        req_data_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b1;
   logic [2:0]        rsp_kind;
   logic signed [8:0] rsp_move_x;
   logic signed [9:0] rsp_move_y;
   logic signed [3:0] rsp_wheel_step;
   logic [2:0]        rsp_button_bits;
   logic [2:0]        rsp_changed_bits;
   logic signed [15:0] rsp_sum_x;
   logic signed [15:0] rsp_sum_y;
   logic signed [15:0] rsp_sum_wheel;
   logic [15:0]       rsp_event_count;

   mouse_tracker tracker = new();
   int           requests_sent = 0;
   int           rsp_hold      = 0;
   int           idle_cycles   = 0;
   bit           calm          = 1'b0;

   ps2_mouse_packet_decoder_top #(
      .ACC_WIDTH (ACC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_move_x       (rsp_move_x),
      .rsp_move_y       (rsp_move_y),
      .rsp_wheel_step   (rsp_wheel_step),
      .rsp_button_bits  (rsp_button_bits),
      .rsp_changed_bits (rsp_changed_bits),
      .rsp_sum_x        (rsp_sum_x),
      .rsp_sum_y        (rsp_sum_y),
      .rsp_sum_wheel    (rsp_sum_wheel),
      .rsp_event_count  (rsp_event_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long; none in a calm stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // stall the result channel at random
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold  <= pick_gap();
      end
   end

   // check every result transfer
   always @(posedge clock) begin
      mouse_result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind         = kind_type'(rsp_kind);
         seen.move_x       = rsp_move_x;
         seen.move_y       = rsp_move_y;
         seen.wheel_step   = rsp_wheel_step;
         seen.button_bits  = rsp_button_bits;
         seen.changed_bits = rsp_changed_bits;
         seen.sum_x        = rsp_sum_x;
         seen.sum_y        = rsp_sum_y;
         seen.sum_wheel    = rsp_sum_wheel;
         seen.event_count  = rsp_event_count;
         tracker.check_result(seen);
      end
   end

   // end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one request transfer, after a random gap
   task automatic send_request(logic mode, logic [7:0] data);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(mode, data);
      requests_sent++;
   endtask

   // register write once every result has drained
   task automatic write_csr(logic idx, logic val);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one packet of the current size, or a lone out-of-sync byte
   task automatic send_packet(motion_type motion, int read_pct);
      logic [7:0] pkt [4];
      int         r;
      int         size;
      int         i;
      size = tracker.wheel_mode ? 4 : 3;
      r    = $urandom_range(0, 99);
      for (i = 0; i < 4; i++) pkt[i] = 8'($urandom);
      case (motion)
         MOTION_RIGHT_UP: begin
            pkt[0] = SYNC_MASK | (pkt[0] & BTN_MASK);
            pkt[1] = 8'hFF;
            pkt[2] = 8'hFF;
         end
         MOTION_LEFT_DOWN: begin
            pkt[0] = SYNC_MASK | X_SIGN_MASK | Y_SIGN_MASK | (pkt[0] & BTN_MASK);
            pkt[1] = 8'h00;
            pkt[2] = 8'h00;
         end
         default: begin
            if (r < 6) begin
               pkt[0] = pkt[0] & ~SYNC_MASK;
               size   = 1;
            end else begin
               pkt[0] = (pkt[0] | SYNC_MASK) & ~OVF_MASK;
               if (r < 16) begin
                  pkt[0] = pkt[0] | (OVF_MASK & 8'($urandom_range(1, 3) << 6));
               end
            end
         end
      endcase
      for (i = 0; i < size; i++) begin
         if (i > 0 && $urandom_range(0, 99) < read_pct) begin
            send_request(REQ_READ, 8'($urandom));
         end
         send_request(REQ_BYTE, pkt[i]);
      end
   endtask

   // one setting of the registers, then a stream of packets and reads
   task automatic run_phase(logic en, logic wheel, motion_type motion, int items,
                            int read_pct);
      int start;
      write_csr(CSR_ENABLED, en);
      write_csr(CSR_WHEEL_MODE, wheel);
      calm  = ($urandom_range(0, 3) == 0);
      start = requests_sent;
      while (requests_sent - start < items) begin
         if ($urandom_range(0, 99) < read_pct) begin
            send_request(REQ_READ, 8'($urandom));
         end else if (tracker.byte_pos != 2'd0) begin
            send_request(REQ_BYTE, 8'($urandom));
         end else begin
            send_packet(motion, read_pct);
         end
      end
      send_request(REQ_READ, 8'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled: both request modes are ignored
      send_request(REQ_BYTE, 8'hFF);
      send_request(REQ_READ, 8'h00);
      write_csr(CSR_ENABLED, 1'b1);

      // out-of-sync first byte, extreme motion, overflow, then a read
      send_request(REQ_BYTE, 8'h00);
      send_request(REQ_BYTE, 8'h0F);
      send_request(REQ_BYTE, 8'hFF);
      send_request(REQ_BYTE, 8'h00);
      send_request(REQ_BYTE, 8'h38);
      send_request(REQ_BYTE, 8'h00);
      send_request(REQ_BYTE, 8'h00);
      send_request(REQ_BYTE, 8'hC8);
      send_request(REQ_BYTE, 8'h12);
      send_request(REQ_BYTE, 8'h34);
      send_request(REQ_READ, 8'hA5);

      // four-byte packet with the most negative wheel step
      write_csr(CSR_WHEEL_MODE, 1'b1);
      send_request(REQ_BYTE, 8'h0C);
      send_request(REQ_BYTE, 8'h55);
      send_request(REQ_BYTE, 8'hAA);
      send_request(REQ_BYTE, 8'hF8);

      // drop to three-byte packets with three bytes held
      send_request(REQ_BYTE, 8'h08);
      send_request(REQ_BYTE, 8'h10);
      send_request(REQ_BYTE, 8'h20);
      write_csr(CSR_WHEEL_MODE, 1'b0);
      send_request(REQ_BYTE, 8'h99);

      // grow to four-byte packets with two bytes held
      send_request(REQ_BYTE, 8'h08);
      send_request(REQ_BYTE, 8'h01);
      write_csr(CSR_WHEEL_MODE, 1'b1);
      send_request(REQ_BYTE, 8'h02);
      send_request(REQ_BYTE, 8'h03);

      // random traffic, including long runs that saturate the sums
      run_phase(1'b1, 1'b0, MOTION_ANY, 100, 4);
      run_phase(1'b1, 1'b1, MOTION_ANY, 150, 4);
      run_phase(1'b1, 1'b0, MOTION_RIGHT_UP, 390, 0);
      run_phase(1'b1, 1'b0, MOTION_LEFT_DOWN, 390, 0);
      run_phase(1'b0, 1'b1, MOTION_ANY, 30, 5);
      run_phase(1'b1, 1'b1, MOTION_ANY, 50, 10);

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: 3- and 4-byte packets, size changes mid-packet,",
               requests_sent);
      $display("  %0d packets, %0d stored, %0d sync drops, %0d overflow drops,",
               tracker.kind_seen[KIND_PACKET], tracker.kind_seen[KIND_STORED],
               tracker.kind_seen[KIND_SYNC], tracker.kind_seen[KIND_OVERFLOW]);
      $display("  %0d reports, %0d ignored; %0d checked, %0d mismatches",
               tracker.kind_seen[KIND_REPORT], tracker.kind_seen[KIND_IGNORED],
               tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== ps2_mouse_packet_decoder_top.f =====
hw/rtl/ps2md_pkg.sv
hw/rtl/ps2_mouse_packet_decoder_top.sv
bench/tb.sv
